>>> sv/window_depth_counter_unit_macros.svh
// assertion macros for the window depth counter unit
// used by window_depth_counter_unit.sv; expects clk and rst_n in scope
`ifndef WINDOW_DEPTH_COUNTER_UNIT_MACROS_SVH
`define WINDOW_DEPTH_COUNTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// checked outside reset
`define WDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, property guards reset itself
`define WDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define WDC_ASSERT(lbl, prop, msg)

`define WDC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> sv/wdc_pkg.sv
// shared constants and types for the window depth counter unit
// no dependencies; used by window_depth_counter_unit.sv and its testbench
`default_nettype none

package wdc_pkg;

  localparam int MAX_WINDOWS_DEF = 4096;

  localparam int CMD_W     = 2;
  localparam int IDX_W     = 12;
  localparam int POS_W     = 31;
  localparam int CNT_W     = 13;
  localparam int DEPTH_W   = 32;
  localparam int TOTAL_W   = 48;
  localparam int CFG_IDX_W = 2;

  // commands
  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WALK_FLANKS   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TMID,
    S_TLO,
    S_THI,
    S_LEFT,
    S_RIGHT,
    S_RDWAIT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

>>> sv/window_depth_counter_unit.sv
// window depth counter: sorted window table with saturating depth counters and a total
// depends on wdc_pkg.sv and window_depth_counter_unit_macros.svh
//
//   channel | signals                                   | handshake
//   --------+-------------------------------------------+----------------------
//   in      | command, window_index, bounds, position   | in_valid / in_ready
//   out     | found, hit_index, counted, depth, total   | out_valid / out_ready
//   cfg     | cfg_index, cfg_wdata                      | cfg_we, no wait
//
// one item at a time; bounds and depths sit in two memories with registered reads
// load and unknown commands go from idle to done and then to the output register; read
// passes through a read-wait state first; add runs the search (about log2(window_count) + 2
// reads), then walks and counts the flank windows: one memory read per cycle, each flank counter
// update sharing the next read; reset is synchronous, no clearing pass; a finished result waits
// in the output register while a new item is already accepted, and the block stalls before its next result
`default_nettype none

`include "window_depth_counter_unit_macros.svh"

module window_depth_counter_unit #(
  parameter int MAX_WINDOWS = wdc_pkg::MAX_WINDOWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [wdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wdc_pkg::POS_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wdc_pkg::CMD_W-1:0]     in_command,
  input  logic [wdc_pkg::IDX_W-1:0]     in_window_index,
  input  logic [wdc_pkg::POS_W-1:0]     in_bound_start,
  input  logic [wdc_pkg::POS_W-1:0]     in_bound_end,
  input  logic [wdc_pkg::POS_W-1:0]     in_position,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_found,
  output logic [wdc_pkg::IDX_W-1:0]     out_hit_index,
  output logic [wdc_pkg::CNT_W-1:0]     out_windows_counted,
  output logic [wdc_pkg::DEPTH_W-1:0]   out_depth_value,
  output logic [wdc_pkg::TOTAL_W-1:0]   out_total_count
);

  localparam int IW = $clog2(MAX_WINDOWS);
  localparam int FW = IW + 1;
  localparam int PW = wdc_pkg::POS_W;
  localparam int DW = wdc_pkg::DEPTH_W;
  localparam int TW = wdc_pkg::TOTAL_W;
  localparam int CW = wdc_pkg::CNT_W;

  // configuration
  logic [CW-1:0] cfg_window_count_r;
  logic [PW-1:0] cfg_region_length_r;
  logic          cfg_walk_flanks_r;

  // memories, bounds packed as {end, start}
  logic [2*PW-1:0] bnd_mem [MAX_WINDOWS];
  logic [DW-1:0]   dep_mem [MAX_WINDOWS];
  logic [2*PW-1:0] bnd_rd_r;
  logic [DW-1:0]   dep_rd_r;

  logic            rd_en;
  logic [IW-1:0]   rd_addr;
  logic            bnd_we;
  logic [IW-1:0]   bnd_waddr;
  logic [2*PW-1:0] bnd_wdata;
  logic            dep_we;
  logic [IW-1:0]   dep_waddr;
  logic [DW-1:0]   dep_wdata;

  wdc_pkg::state_t state_r, state_nxt;
  logic [IW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [FW-1:0] cnt_r, cnt_nxt;
  logic [FW-1:0] flank_r, flank_nxt;
  logic [IW-1:0] hit_r, hit_nxt;
  logic          found_r, found_nxt;
  logic [CW-1:0] counted_r, counted_nxt;
  logic [DW-1:0] depth_res_r, depth_res_nxt;
  logic [TW-1:0] total_r, total_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_load;
  logic          out_found_r;
  logic [wdc_pkg::IDX_W-1:0] out_hit_index_r;
  logic [CW-1:0] out_counted_r;
  logic [DW-1:0] out_depth_r;
  logic [TW-1:0] out_total_r;

  logic [PW-1:0] win_start, win_end;
  logic          in_half, in_closed;

  assign win_start = bnd_rd_r[PW-1:0];
  assign win_end   = bnd_rd_r[2*PW-1:PW];
  assign in_half   = (pos_r >= win_start) && (pos_r < win_end);
  assign in_closed = (pos_r >= win_start) && (pos_r <= win_end);

  assign in_ready            = (state_r == wdc_pkg::S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_found           = out_found_r;
  assign out_hit_index       = out_hit_index_r;
  assign out_windows_counted = out_counted_r;
  assign out_depth_value     = out_depth_r;
  assign out_total_count     = out_total_r;

  always_ff @(posedge clk) begin
    if (bnd_we) begin
      bnd_mem[bnd_waddr] <= bnd_wdata;
    end
    if (rd_en) begin
      bnd_rd_r <= bnd_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (dep_we) begin
      dep_mem[dep_waddr] <= dep_wdata;
    end
    if (rd_en) begin
      dep_rd_r <= dep_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_window_count_r  <= '0;
      cfg_region_length_r <= '0;
      cfg_walk_flanks_r   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        wdc_pkg::CFG_WINDOW_COUNT:  cfg_window_count_r  <= cfg_wdata[CW-1:0];
        wdc_pkg::CFG_REGION_LENGTH: cfg_region_length_r <= cfg_wdata;
        wdc_pkg::CFG_WALK_FLANKS:   cfg_walk_flanks_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic          idx_ok;
    logic [FW-1:0] cnt_eff;
    logic [IW-1:0] hi0;
    logic          probe;
    logic [IW-1:0] plo, phi, pmid;
    logic [FW-1:0] mid_sum;
    logic          do_hit;
    logic [IW-1:0] w;
    logic          do_bump;
    logic [IW-1:0] baddr;
    logic          go_right;
    logic [IW-1:0] rbase;
    logic [FW-1:0] rnext;

    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    flank_nxt     = flank_r;
    hit_nxt       = hit_r;
    found_nxt     = found_r;
    counted_nxt   = counted_r;
    depth_res_nxt = depth_res_r;
    total_nxt     = total_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    bnd_we        = 1'b0;
    bnd_waddr     = IW'(in_window_index);
    bnd_wdata     = {in_bound_end, in_bound_start};
    dep_we        = 1'b0;
    dep_waddr     = '0;
    dep_wdata     = '0;
    out_load      = 1'b0;

    probe    = 1'b0;
    plo      = '0;
    phi      = '0;
    pmid     = '0;
    mid_sum  = '0;
    do_hit   = 1'b0;
    w        = '0;
    do_bump  = 1'b0;
    baddr    = '0;
    go_right = 1'b0;
    rbase    = '0;
    rnext    = '0;

    idx_ok = (32'(in_window_index) < 32'(MAX_WINDOWS));
    // a count above the table is clamped
    if (32'(cfg_window_count_r) > 32'(MAX_WINDOWS)) begin
      cnt_eff = FW'(MAX_WINDOWS);
    end else begin
      cnt_eff = FW'(cfg_window_count_r);
    end
    hi0 = IW'(cnt_eff - FW'(1));

    case (state_r)
      wdc_pkg::S_IDLE: begin
        if (in_valid) begin
          found_nxt     = 1'b0;
          hit_nxt       = '0;
          counted_nxt   = '0;
          depth_res_nxt = '0;
          pos_nxt       = in_position;
          cnt_nxt       = cnt_eff;
          state_nxt     = wdc_pkg::S_DONE;
          case (in_command)
            wdc_pkg::CMD_LOAD: begin
              if (idx_ok) begin
                bnd_we    = 1'b1;
                dep_we    = 1'b1;
                dep_waddr = IW'(in_window_index);
                dep_wdata = '0;
              end
            end
            wdc_pkg::CMD_ADD: begin
              if ((in_position < cfg_region_length_r) && (cnt_eff != '0)) begin
                probe = 1'b1;
                plo   = '0;
                phi   = hi0;
              end
            end
            wdc_pkg::CMD_READ: begin
              if (idx_ok) begin
                rd_en     = 1'b1;
                rd_addr   = IW'(in_window_index);
                state_nxt = wdc_pkg::S_RDWAIT;
              end
            end
            default: ;
          endcase
        end
      end
      wdc_pkg::S_TMID: begin
        if (in_half) begin
          do_hit = 1'b1;
          w      = mid_r;
        end else begin
          probe = 1'b1;
          if (pos_r < win_start) begin
            plo = lo_r;
            phi = mid_r;
          end else begin
            plo = mid_r;
            phi = hi_r;
          end
        end
      end
      wdc_pkg::S_TLO: begin
        if (in_half) begin
          do_hit = 1'b1;
          w      = lo_r;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = hi_r;
          state_nxt = wdc_pkg::S_THI;
        end
      end
      wdc_pkg::S_THI: begin
        if (in_half) begin
          do_hit = 1'b1;
          w      = hi_r;
        end else begin
          state_nxt = wdc_pkg::S_DONE;
        end
      end
      wdc_pkg::S_LEFT: begin
        if (in_closed) begin
          do_bump = 1'b1;
          baddr   = IW'(flank_r);
          if (flank_r != '0) begin
            rd_en     = 1'b1;
            rd_addr   = IW'(flank_r - FW'(1));
            flank_nxt = flank_r - FW'(1);
          end else begin
            go_right = 1'b1;
            rbase    = hit_r;
          end
        end else begin
          go_right = 1'b1;
          rbase    = hit_r;
        end
      end
      wdc_pkg::S_RIGHT: begin
        if (in_closed) begin
          do_bump = 1'b1;
          baddr   = IW'(flank_r);
          if ((flank_r + FW'(1)) < cnt_r) begin
            rd_en     = 1'b1;
            rd_addr   = IW'(flank_r + FW'(1));
            flank_nxt = flank_r + FW'(1);
          end else begin
            state_nxt = wdc_pkg::S_DONE;
          end
        end else begin
          state_nxt = wdc_pkg::S_DONE;
        end
      end
      wdc_pkg::S_RDWAIT: begin
        depth_res_nxt = dep_rd_r;
        state_nxt     = wdc_pkg::S_DONE;
      end
      wdc_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = wdc_pkg::S_IDLE;
        end
      end
      default: state_nxt = wdc_pkg::S_IDLE;
    endcase

    // search hit: count it, then start the flank walk if enabled, left side first unless the hit is window 0
    if (do_hit) begin
      found_nxt = 1'b1;
      hit_nxt   = w;
      do_bump   = 1'b1;
      baddr     = w;
      if (cfg_walk_flanks_r) begin
        if (w != '0) begin
          rd_en     = 1'b1;
          rd_addr   = w - IW'(1);
          flank_nxt = FW'(w) - FW'(1);
          state_nxt = wdc_pkg::S_LEFT;
        end else begin
          go_right = 1'b1;
          rbase    = w;
        end
      end else begin
        state_nxt = wdc_pkg::S_DONE;
      end
    end

    if (go_right) begin
      rnext = FW'(rbase) + FW'(1);
      if (rnext < cnt_r) begin
        rd_en     = 1'b1;
        rd_addr   = IW'(rnext);
        flank_nxt = rnext;
        state_nxt = wdc_pkg::S_RIGHT;
      end else begin
        state_nxt = wdc_pkg::S_DONE;
      end
    end

    // saturating counter update on the window just read
    if (do_bump) begin
      dep_we      = 1'b1;
      dep_waddr   = baddr;
      dep_wdata   = (dep_rd_r == '1) ? dep_rd_r : dep_rd_r + DW'(1);
      total_nxt   = (total_r == '1) ? total_r : total_r + TW'(1);
      counted_nxt = counted_r + CW'(1);
    end

    // next search read: the two end windows once the range is down to two or fewer
    if (probe) begin
      mid_sum = FW'(plo) + FW'(phi);
      pmid    = mid_sum[FW-1:1];
      lo_nxt  = plo;
      hi_nxt  = phi;
      mid_nxt = pmid;
      rd_en   = 1'b1;
      if ((plo == pmid) || (phi == pmid)) begin
        rd_addr   = plo;
        state_nxt = wdc_pkg::S_TLO;
      end else begin
        rd_addr   = pmid;
        state_nxt = wdc_pkg::S_TMID;
      end
    end

    out_valid_nxt = (out_valid_r && !out_ready) || out_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wdc_pkg::S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    pos_r       <= pos_nxt;
    cnt_r       <= cnt_nxt;
    flank_r     <= flank_nxt;
    hit_r       <= hit_nxt;
    found_r     <= found_nxt;
    counted_r   <= counted_nxt;
    depth_res_r <= depth_res_nxt;
    if (out_load) begin
      out_found_r     <= found_r;
      out_hit_index_r <= wdc_pkg::IDX_W'(hit_r);
      out_counted_r   <= counted_r;
      out_depth_r     <= depth_res_r;
      out_total_r     <= total_r;
    end
  end

  `WDC_ASSERT(a_no_rw_same_entry, (dep_we && rd_en) |-> (dep_waddr != rd_addr), "depth read and write collide on one entry")
  `WDC_ASSERT_ALWAYS(a_total_monotonic, (rst_n && $past(rst_n)) |-> (total_r >= $past(total_r)), "total count went down")
  `WDC_ASSERT(a_flank_needs_walk, ((state_r == wdc_pkg::S_LEFT) || (state_r == wdc_pkg::S_RIGHT)) |-> cfg_walk_flanks_r, "flank walk with walking off")
  `WDC_ASSERT(a_miss_counts_none, (out_valid_r && !out_found_r) |-> (out_counted_r == '0), "windows counted without a search hit")

endmodule

`default_nettype wire

>>> test/window_depth_counter_unit_test.sv
// self-checking testbench for window_depth_counter_unit: window table loads, position adds, reads
// needs wdc_pkg.sv and the unit itself; predicts each result and checks it in order
module window_depth_counter_unit_test;
  import wdc_pkg::*;

  localparam int NWIN = MAX_WINDOWS_DEF;
  localparam int IDLE_PCT = 28;
  localparam int LIMIT_CYCLES = 1500000;
  localparam int RANDOM_ITEMS = 1250;
  localparam int PRINT_CAP = 50;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  typedef struct {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] window_index;
    logic [POS_W-1:0] bound_start;
    logic [POS_W-1:0] bound_end;
    logic [POS_W-1:0] position;
  } window_item_t;

  typedef struct {
    logic               found;
    logic [IDX_W-1:0]   hit_index;
    logic [CNT_W-1:0]   windows_counted;
    logic [DEPTH_W-1:0] depth_value;
    logic [TOTAL_W-1:0] total_count;
  } depth_answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW_COUNT;
  logic [POS_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] in_command = CMD_LOAD;
  logic [IDX_W-1:0] in_window_index = '0;
  logic [POS_W-1:0] in_bound_start = '0;
  logic [POS_W-1:0] in_bound_end = '0;
  logic [POS_W-1:0] in_position = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_found;
  logic [IDX_W-1:0] out_hit_index;
  logic [CNT_W-1:0] out_windows_counted;
  logic [DEPTH_W-1:0] out_depth_value;
  logic [TOTAL_W-1:0] out_total_count;

  window_depth_counter_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_window_index    (in_window_index),
    .in_bound_start     (in_bound_start),
    .in_bound_end       (in_bound_end),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_found          (out_found),
    .out_hit_index      (out_hit_index),
    .out_windows_counted(out_windows_counted),
    .out_depth_value    (out_depth_value),
    .out_total_count    (out_total_count)
  );

  always #4 clk = ~clk;

  // predicted table state, updated as items are accepted
  bit [POS_W-1:0]   tbl_start [NWIN];
  bit [POS_W-1:0]   tbl_end   [NWIN];
  bit [DEPTH_W-1:0] tbl_depth [NWIN];
  bit [TOTAL_W-1:0] tbl_total = '0;
  logic [CNT_W-1:0] cur_wcount = '0;
  logic [POS_W-1:0] cur_region = '0;
  logic             cur_walk = 1'b1;

  // what the stimulus side has loaded so far
  bit [POS_W-1:0] gen_start [NWIN];
  bit [POS_W-1:0] gen_end   [NWIN];
  bit             gen_loaded [NWIN];
  int             loaded_list [$];

  window_item_t  item_backlog [$];
  depth_answer_t predicted_answers [$];
  window_item_t  on_bus;
  depth_answer_t want;

  logic steady = 1'b0;
  int cycle_count = 0;
  int error_count = 0;
  int queued_total = 0;
  int checked_total = 0;
  int random_queued = 0;
  int phases_run = 0;
  int n_load = 0, n_add = 0, n_read = 0, n_other = 0, n_hits = 0;

  task automatic flag(string msg);
    if (error_count < PRINT_CAP)
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic bit half_open(int i, logic [POS_W-1:0] pos);
    return pos >= tbl_start[i] && pos < tbl_end[i];
  endfunction

  function automatic bit closed_cover(int i, logic [POS_W-1:0] pos);
    return pos >= tbl_start[i] && pos <= tbl_end[i];
  endfunction

  // fixed binary search, stops when either bound meets the midpoint
  function automatic int locate_window(int cnt, logic [POS_W-1:0] pos);
    int lo, hi, mid, hit;
    bit done;
    lo = 0;
    hi = cnt - 1;
    mid = (lo + hi) / 2;
    hit = -1;
    done = 1'b0;
    while (!done) begin
      if (lo > hi) begin
        done = 1'b1;
      end else if (lo == mid || hi == mid) begin
        if (half_open(lo, pos)) hit = lo;
        else if (half_open(hi, pos)) hit = hi;
        done = 1'b1;
      end else if (half_open(mid, pos)) begin
        hit = mid;
        done = 1'b1;
      end else begin
        if (pos < tbl_start[mid]) hi = mid;
        else lo = mid;
        mid = (lo + hi) / 2;
      end
    end
    return hit;
  endfunction

  function automatic void bump_depth(int i);
    if (tbl_depth[i] != '1) tbl_depth[i]++;
    if (tbl_total != '1) tbl_total++;
  endfunction

  function automatic depth_answer_t tally_item(window_item_t it);
    depth_answer_t a;
    int eff, w, f;
    a.found = 1'b0;
    a.hit_index = '0;
    a.windows_counted = '0;
    a.depth_value = '0;
    case (it.command)
      CMD_LOAD: begin
        tbl_start[it.window_index] = it.bound_start;
        tbl_end[it.window_index] = it.bound_end;
        tbl_depth[it.window_index] = '0;
      end
      CMD_ADD: begin
        if (it.position < cur_region) begin
          eff = (cur_wcount > NWIN) ? NWIN : int'(cur_wcount);
          w = locate_window(eff, it.position);
          if (w >= 0) begin
            a.found = 1'b1;
            a.hit_index = w[IDX_W-1:0];
            bump_depth(w);
            a.windows_counted = 1;
            if (cur_walk) begin
              f = w - 1;
              while (f >= 0 && closed_cover(f, it.position)) begin
                bump_depth(f);
                a.windows_counted = a.windows_counted + 1;
                f--;
              end
              f = w + 1;
              while (f < eff && closed_cover(f, it.position)) begin
                bump_depth(f);
                a.windows_counted = a.windows_counted + 1;
                f++;
              end
            end
          end
        end
      end
      CMD_READ: a.depth_value = tbl_depth[it.window_index];
      default: ;
    endcase
    a.total_count = tbl_total;
    return a;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               queued_total - checked_total);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // driver: presents items from the backlog, predicts on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_answers.push_back(tally_item(on_bus));
        case (on_bus.command)
          CMD_LOAD: n_load++;
          CMD_ADD:  n_add++;
          CMD_READ: n_read++;
          default:  n_other++;
        endcase
      end
      if (!in_valid || in_ready) begin
        if (item_backlog.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          on_bus = item_backlog.pop_front();
          in_valid <= 1'b1;
          in_command <= on_bus.command;
          in_window_index <= on_bus.window_index;
          in_bound_start <= on_bus.bound_start;
          in_bound_end <= on_bus.bound_end;
          in_position <= on_bus.position;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_answers.size() == 0) begin
          flag("result with no item outstanding");
        end else begin
          want = predicted_answers.pop_front();
          if (out_found !== want.found)
            flag($sformatf("found got %0d want %0d", out_found, want.found));
          if (out_hit_index !== want.hit_index)
            flag($sformatf("hit_index got %0d want %0d", out_hit_index, want.hit_index));
          if (out_windows_counted !== want.windows_counted)
            flag($sformatf("windows_counted got %0d want %0d", out_windows_counted,
                           want.windows_counted));
          if (out_depth_value !== want.depth_value)
            flag($sformatf("depth_value got %0d want %0d", out_depth_value,
                           want.depth_value));
          if (out_total_count !== want.total_count)
            flag($sformatf("total_count got %0d want %0d", out_total_count,
                           want.total_count));
          if (want.found) n_hits++;
          checked_total++;
        end
      end
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  function automatic longint draw(int unsigned hi);
    longint v;
    v = $urandom_range(0, hi);
    return v;
  endfunction

  function automatic logic [POS_W-1:0] clip31(longint v);
    if (v < 0) return '0;
    if (v > longint'(POS_MAX)) return POS_MAX;
    return v[POS_W-1:0];
  endfunction

  function automatic window_item_t noise_item(logic [CMD_W-1:0] cmd);
    window_item_t it;
    it.command = cmd;
    it.window_index = $urandom_range(0, NWIN - 1);
    it.bound_start = $urandom;
    it.bound_end = $urandom;
    it.position = $urandom;
    return it;
  endfunction

  function automatic int loaded_prefix();
    int n;
    n = 0;
    while (n < NWIN && gen_loaded[n]) n++;
    return n;
  endfunction

  task automatic queue_item(window_item_t it);
    item_backlog.push_back(it);
    queued_total++;
    if (it.command == CMD_LOAD) begin
      gen_start[it.window_index] = it.bound_start;
      gen_end[it.window_index] = it.bound_end;
      if (!gen_loaded[it.window_index]) begin
        gen_loaded[it.window_index] = 1'b1;
        loaded_list.push_back(it.window_index);
      end
    end
  endtask

  task automatic load_window(int idx, longint s, longint e);
    window_item_t it;
    it = noise_item(CMD_LOAD);
    it.window_index = idx;
    it.bound_start = clip31(s);
    it.bound_end = clip31(e);
    queue_item(it);
  endtask

  task automatic add_at(logic [POS_W-1:0] p);
    window_item_t it;
    it = noise_item(CMD_ADD);
    it.position = p;
    queue_item(it);
  endtask

  task automatic read_at(int idx);
    window_item_t it;
    it = noise_item(CMD_READ);
    it.window_index = idx;
    queue_item(it);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WINDOW_COUNT:  cur_wcount = val[CNT_W-1:0];
      CFG_REGION_LENGTH: cur_region = val;
      CFG_WALK_FLANKS:   cur_walk = val[0];
      default: ;
    endcase
  endtask

  // wait until every queued item has answered, plus a little slack
  task automatic settle();
    while (checked_total != queued_total) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // sorted, overlapping windows with the odd empty or inverted one
  task automatic build_table(int n, int unsigned scale);
    longint s, e;
    int r;
    s = draw(scale);
    for (int i = 0; i < n; i++) begin
      s = s + draw(scale);
      e = s + draw(2 * scale);
      r = $urandom_range(0, 15);
      if (r == 0) e = s;
      else if (r == 1) e = s - 1 - draw(scale);
      load_window(i, s, e);
    end
  endtask

  function automatic logic [POS_W-1:0] pick_position();
    int eff, j, r;
    longint s0, e0, v;
    logic [POS_W-1:0] p;
    eff = (cur_wcount > NWIN) ? NWIN : int'(cur_wcount);
    r = $urandom_range(0, 99);
    if (eff == 0 || r >= 90) begin
      p = $urandom;
    end else begin
      j = $urandom_range(0, eff - 1);
      s0 = gen_start[j];
      e0 = gen_end[j];
      if (r < 45) begin
        v = s0 + draw((e0 > s0) ? e0 - s0 : 0);
      end else if (r < 60) begin
        case (draw(3))
          0: v = s0;
          1: v = e0;
          2: v = e0 - 1;
          default: v = e0 + 1;
        endcase
      end else if (r < 75) begin
        v = s0 - draw(64);
      end else begin
        v = draw(gen_end[eff - 1]);
      end
      p = clip31(v);
    end
    // positions at and just past the region length
    if (cur_region != 0 && draw(11) == 0) p = clip31(longint'(cur_region) + draw(2));
    return p;
  endfunction

  task automatic mixed_items(int count);
    int r, pre, j;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      pre = loaded_prefix();
      if (r < 55 || loaded_list.size() == 0) begin
        add_at(pick_position());
      end else if (r < 75) begin
        read_at(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
      end else if (r < 88 && pre > 0) begin
        j = $urandom_range(0, pre - 1);
        if ($urandom_range(0, 2) != 0) load_window(j, gen_start[j], gen_end[j]);
        else load_window(j, draw(POS_MAX), draw(POS_MAX));
      end else if (r < 93) begin
        load_window($urandom_range(0, NWIN - 1), draw(POS_MAX), draw(POS_MAX));
      end else begin
        queue_item(noise_item(CMD_NONE));
      end
    end
  endtask

  task automatic table_phase();
    int r, n, wc, pre, before_count;
    int unsigned scale;
    logic [POS_W-1:0] region;
    before_count = queued_total;
    r = $urandom_range(0, 9);
    n = (r < 7) ? $urandom_range(1, 16) : (r < 9) ? $urandom_range(17, 128) : 0;
    case ($urandom_range(0, 3))
      0: scale = 8;
      1: scale = 1000;
      2: scale = 1 << 20;
      default: scale = POS_MAX / (n + 2);
    endcase
    build_table(n, scale);
    settle();
    pre = loaded_prefix();
    if ($urandom_range(0, 3) == 0) wc = $urandom_range(0, pre);
    else wc = (n < pre) ? n : pre;
    r = $urandom_range(0, 9);
    if (r < 5) region = POS_MAX;
    else if (r < 8) region = clip31(draw((wc > 0) ? gen_end[wc - 1] : 1000));
    else if (r < 9) region = '0;
    else region = $urandom;
    write_reg(CFG_WINDOW_COUNT, wc);
    write_reg(CFG_REGION_LENGTH, region);
    write_reg(CFG_WALK_FLANKS, $urandom_range(0, 3) != 0);
    mixed_items($urandom_range(80, 160));
    random_queued += queued_total - before_count;
    phases_run++;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: empty region, no windows
    add_at(0);
    queue_item(noise_item(CMD_NONE));
    settle();
    write_reg(CFG_REGION_LENGTH, POS_MAX);
    add_at(12345);
    load_window(0, 100, 200);
    load_window(1, 150, 300);
    load_window(2, 300, 400);
    load_window(3, 390, 500);
    load_window(4, 600, 700);
    load_window(5, 32'h7FFF_FFF0, POS_MAX);
    load_window(NWIN - 1, POS_MAX, 0);
    read_at(NWIN - 1);
    read_at(0);
    settle();
    write_reg(CFG_WINDOW_COUNT, 6);
    // overlap on both flanks, closed end boundary, top of range, misses
    add_at(150);
    add_at(300);
    add_at(399);
    add_at(POS_MAX - 1);
    add_at(POS_MAX);
    add_at(50);
    add_at(550);
    read_at(1);
    read_at(3);
    settle();
    write_reg(CFG_WALK_FLANKS, 0);
    write_reg(CFG_WINDOW_COUNT, 1);
    add_at(150);
    settle();
    write_reg(CFG_WINDOW_COUNT, 2);
    add_at(250);
    load_window(1, 150, 300);
    read_at(1);

    while (random_queued < RANDOM_ITEMS) begin
      steady <= (phases_run == 1);
      table_phase();
    end

    // full table, count register above the table size
    settle();
    steady <= 1'b1;
    build_table(NWIN, 1 << 19);
    settle();
    write_reg(CFG_WINDOW_COUNT, 13'h1FFF);
    write_reg(CFG_REGION_LENGTH, POS_MAX);
    write_reg(CFG_WALK_FLANKS, 1);
    steady <= 1'b0;
    mixed_items(150);
    settle();
    write_reg(CFG_WINDOW_COUNT, NWIN);
    write_reg(CFG_WALK_FLANKS, 0);
    mixed_items(100);
    settle();
    write_reg(CFG_REGION_LENGTH, 0);
    add_at(0);
    add_at(POS_MAX);
    queue_item(noise_item(CMD_NONE));

    settle();
    repeat (24) @(posedge clk);
    $display("%0d items: %0d loads, %0d adds (%0d hits), %0d reads, %0d unknown", queued_total,
             n_load, n_add, n_hits, n_read, n_other);
    $display("%0d table settings plus a full %0d-window table, %0d results checked",
             phases_run, NWIN, checked_total);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/wdc_pkg.sv
sv/window_depth_counter_unit.sv
test/window_depth_counter_unit_test.sv
